[rtl/psf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_pkg
// Shared types and constants for the payload multi-string filter.
// ----------------------------------------------------------------------------
package psf_pkg;

   localparam int PAT_REGS   = 4;   // pattern registers in the register map
   localparam int PAT_W      = 64;  // bits per pattern register
   localparam int LEN_W      = 4;   // bits per length nibble
   localparam int LENS_W     = 16;  // pattern_lengths register width
   localparam int EXCL_W     = 4;   // pattern_is_exclusion register width
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int BYTE_W     = 8;

   typedef logic [BYTE_W-1:0]     byte_type;
   typedef logic [PAT_W-1:0]      pattern_type;
   typedef logic [LEN_W-1:0]      len_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;

   localparam csr_index_type CSR_PATTERN_0   = 3'd0;
   localparam csr_index_type CSR_PATTERN_1   = 3'd1;
   localparam csr_index_type CSR_PATTERN_2   = 3'd2;
   localparam csr_index_type CSR_PATTERN_3   = 3'd3;
   localparam csr_index_type CSR_PATTERN_LEN = 3'd4;
   localparam csr_index_type CSR_PATTERN_EXC = 3'd5;

endpackage

[rtl/psf_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_match
// Compares one pattern against the newest bytes of the history window.
// ----------------------------------------------------------------------------
module psf_match import psf_pkg::*; #(
   parameter int MAX_BYTES = 8,
   parameter int FILL_W    = 4
) (
   input  pattern_type                  pattern,
   input  len_type                      len_nibble,
   input  logic [BYTE_W*MAX_BYTES-1:0]  hist,      // byte j = j-th newest, newest at j=0
   input  logic [FILL_W-1:0]            have,      // bytes held including the new one
   output logic                         hit
);

   localparam len_type MAX_LEN = LEN_W'(MAX_BYTES);

   len_type              len_eff;
   logic [MAX_BYTES:0]   match_at;  // match_at[L]: pattern of length L ends at newest byte

   always_comb begin
      len_eff = (len_nibble > MAX_LEN) ? MAX_LEN : len_nibble;
   end

   always_comb begin
      match_at = '0;
      for (int l = 1; l <= MAX_BYTES; l++) begin
         match_at[l] = 1'b1;
         for (int i = 0; i < MAX_BYTES; i++) begin
            if (i < l) begin
               if (pattern[BYTE_W*i +: BYTE_W] != hist[BYTE_W*(l-1-i) +: BYTE_W]) begin
                  match_at[l] = 1'b0;
               end
            end
         end
      end
   end

   // length zero selects match_at[0], which is always clear
   assign hit = match_at[len_eff[FILL_W-1:0]] && (LEN_W'(have) >= len_eff);

endmodule

[rtl/payload_multi_string_filter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// payload_multi_string_filter_top
// Per-packet include/exclude substring filter over a sliding byte window.
// ----------------------------------------------------------------------------
// The verdict is registered: it is on rsp in the cycle after the request with tlast is taken.
// Throughput: one request per cycle; the window compare for all patterns
//   finishes in the cycle the byte is taken, so only rsp backpressure stalls.
// Reset: synchronous, active high; clears registers, window, fill and flags.
//   req_tready and csr_ready are low while reset is high.
module payload_multi_string_filter_top import psf_pkg::*; #(
   parameter int NUM_PATTERNS      = 4,
   parameter int MAX_PATTERN_BYTES = 8
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] data_byte
   input  logic [1:0]             req_tuser,   // [0] byte_valid, [1] has_payload
   input  logic                   req_tlast,   // last_byte

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [0] accept, [7:1] zero

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  csr_index_type          csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int NP     = (NUM_PATTERNS < PAT_REGS) ? NUM_PATTERNS : PAT_REGS;
   localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN_BYTES - 1);

   pattern_type          pattern_ff [PAT_REGS];
   logic [LENS_W-1:0]    lengths_ff;
   logic [EXCL_W-1:0]    excl_ff;

   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [NP-1:0]        flags_ff, flags_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_accept_ff, rsp_accept_in;

   logic                 req_fire;
   logic                 byte_valid;
   logic                 has_payload;
   logic [FILL_W-1:0]    have;
   logic [BYTE_W*MAX_PATTERN_BYTES-1:0] hist;
   logic [NP-1:0]        hits;
   logic [NP-1:0]        found;
   logic                 verdict;

   assign byte_valid  = req_tuser[0];
   assign has_payload = req_tuser[1];

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = !reset;

   // ---------------- register map ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PAT_REGS; k++) begin
            pattern_ff[k] <= '0;
         end
         lengths_ff <= '0;
         excl_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PATTERN_0:   pattern_ff[0] <= csr_data;
            CSR_PATTERN_1:   pattern_ff[1] <= csr_data;
            CSR_PATTERN_2:   pattern_ff[2] <= csr_data;
            CSR_PATTERN_3:   pattern_ff[3] <= csr_data;
            CSR_PATTERN_LEN: lengths_ff    <= csr_data[LENS_W-1:0];
            CSR_PATTERN_EXC: excl_ff       <= csr_data[EXCL_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- history window ----------------
   assign hist[BYTE_W-1:0] = req_tdata;
   assign have = fill_ff + FILL_W'(1);

   generate
      if (MAX_PATTERN_BYTES > 1) begin : g_win
         localparam int WIN_N = MAX_PATTERN_BYTES - 1;
         byte_type win_ff [WIN_N];

         for (genvar j = 0; j < WIN_N; j++) begin : g_tap
            assign hist[BYTE_W*(j+1) +: BYTE_W] = win_ff[j];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               for (int j = 0; j < WIN_N; j++) begin
                  win_ff[j] <= '0;
               end
            end else if (req_fire) begin
               if (req_tlast) begin
                  for (int j = 0; j < WIN_N; j++) begin
                     win_ff[j] <= '0;
                  end
               end else if (byte_valid) begin
                  win_ff[0] <= req_tdata;
                  for (int j = 1; j < WIN_N; j++) begin
                     win_ff[j] <= win_ff[j-1];
                  end
               end
            end
         end
      end
   endgenerate

   // ---------------- pattern compare ----------------
   generate
      for (genvar k = 0; k < NP; k++) begin : g_pat
         psf_match #(
            .MAX_BYTES (MAX_PATTERN_BYTES),
            .FILL_W    (FILL_W)
         ) u_match (
            .pattern    (pattern_ff[k]),
            .len_nibble (lengths_ff[LEN_W*k +: LEN_W]),
            .hist       (hist),
            .have       (have),
            .hit        (hits[k])
         );
      end
   endgenerate

   assign found = flags_ff | (hits & {NP{byte_valid}});

   always_comb begin
      verdict = has_payload;
      for (int k = 0; k < NP; k++) begin
         if ((lengths_ff[LEN_W*k +: LEN_W] != '0) && (excl_ff[k] == found[k])) begin
            verdict = 1'b0;
         end
      end
   end

   // ---------------- next state ----------------
   always_comb begin
      fill_in       = fill_ff;
      flags_in      = flags_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_accept_in = rsp_accept_ff;
      if (req_fire) begin
         if (req_tlast) begin
            fill_in       = '0;
            flags_in      = '0;
            rsp_valid_in  = 1'b1;
            rsp_accept_in = verdict;
         end else if (byte_valid) begin
            fill_in  = (fill_ff == FILL_MAX) ? FILL_MAX : have;
            flags_in = found;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_accept_ff <= rsp_accept_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_accept_ff};

endmodule

[rtl/psf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_checker
// Port-level checks for the payload filter, bound to the top level.
// ----------------------------------------------------------------------------
module psf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // no verdict may appear straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // a stalled verdict holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp dropped or changed while stalled");

   // every request that ends a packet yields a verdict next cycle
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("missing verdict after last request");

   // mid-packet requests never produce a verdict
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast && !(rsp_tvalid && !rsp_tready)
      |=> !rsp_tvalid)
      else $error("verdict without last request");

   // only the accept bit is ever set
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'b0)
      else $error("rsp padding bits set");

endmodule

bind payload_multi_string_filter_top psf_checker u_psf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
